// File: hdl/lfsr_noise_sound_channel_top_assert.svh
`ifndef LFSR_NOISE_SOUND_CHANNEL_TOP_ASSERT_SVH
`define LFSR_NOISE_SOUND_CHANNEL_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LNSC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lnsc assertion failed: same-cycle implication");

`define LNSC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lnsc assertion failed: next-cycle implication");

`else

`define LNSC_ASSERT_IMP(label, clk, rst, pre, post)

`define LNSC_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: hdl/lnsc_pkg.sv
`default_nettype none

package lnsc_pkg;

   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_LENGTH   = 3'd1;
   localparam logic [2:0] FUNC_ENVELOPE = 3'd2;
   localparam logic [2:0] FUNC_READ     = 3'd3;
   localparam logic [2:0] FUNC_WRITE    = 3'd4;
   localparam logic [2:0] FUNC_POWER    = 3'd5;

   localparam logic [15:0] ADDR_LENGTH   = 16'hFF20;
   localparam logic [15:0] ADDR_ENVELOPE = 16'hFF21;
   localparam logic [15:0] ADDR_POLY     = 16'hFF22;
   localparam logic [15:0] ADDR_CONTROL  = 16'hFF23;

   localparam logic [7:0]  RDATA_IDLE       = 8'hFF;
   localparam logic [3:0]  CLOCK_SHIFT_STOP = 4'd14;
   localparam logic [6:0]  LENGTH_FULL      = 7'd64;
   localparam logic [14:0] LFSR_SEED        = 15'h7FFF;
   localparam logic [3:0]  ENV_COUNT_ZERO_PERIOD = 4'd8;

   localparam logic [5:0] DIVISOR_TABLE [8] = '{
      6'd4, 6'd8, 6'd16, 6'd24, 6'd32, 6'd40, 6'd48, 6'd56
   };

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        phase_odd;
      logic        init_length;
   } request_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic [3:0] sample_out;
      logic       channel_on;
   } result_type;

   typedef struct packed {
      logic [14:0] shift_reg;
      logic [31:0] period_count;
      logic [3:0]  clock_shift;
      logic        narrow_mode;
      logic [2:0]  divisor_code;
      logic [6:0]  length_left;
      logic        length_on;
      logic [3:0]  env_start_volume;
      logic        env_up;
      logic [2:0]  env_period;
      logic [3:0]  env_count;
      logic [3:0]  level;
      logic        active;
      logic [3:0]  last_sample;
   } state_type;

   function automatic logic [31:0] reload_value(input logic [2:0] code,
                                                input logic [3:0] shift);
      return {26'd0, DIVISOR_TABLE[code]} << shift;
   endfunction

endpackage

`default_nettype wire

// File: hdl/lfsr_noise_sound_channel_top.sv
// Channel   Direction  Handshake        Payload
// req       in         req_valid/stall  func, addr, wdata, phase_odd, init_length
// rsp       out        rsp_valid/stall  rdata, sample_out, channel_on
//
// One request per cycle sustained while rsp_stall stays low; a request passes
// the input register, then the result register, with one pass of event logic between.
// Synchronous active-high reset clears all channel state and both stages.
// A stalled result holds while one more request waits in the input register;
// req_stall rises only when both stages are full and rsp_stall is high.
`default_nettype none

`include "lfsr_noise_sound_channel_top_assert.svh"

module lfsr_noise_sound_channel_top
   import lnsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [15:0] req_addr,
   input  wire logic [7:0]  req_wdata,
   input  wire logic        req_phase_odd,
   input  wire logic        req_init_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_rdata,
   output logic [3:0]       rsp_sample_out,
   output logic             rsp_channel_on
);

   logic        stage_valid_ff;
   request_type stage_req_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  result;
   state_type   state;
   logic        advance;
   logic        fire;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = stage_valid_ff && advance;
   assign req_stall = stage_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (!req_stall) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= stage_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_req_ff <= '{func: req_func, addr: req_addr, wdata: req_wdata,
                           phase_odd: req_phase_odd, init_length: req_init_length};
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   lnsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .req    (stage_req_ff),
      .result (result),
      .state  (state)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_rdata      = out_ff.rdata;
   assign rsp_sample_out = out_ff.sample_out;
   assign rsp_channel_on = out_ff.channel_on;

   `LNSC_ASSERT_NEXT(a_fire_fills_output, clock, reset, fire, rsp_valid)
   `LNSC_ASSERT_NEXT(a_power_silences, clock, reset,
      fire && stage_req_ff.func == FUNC_POWER,
      rsp_sample_out == 4'd0 && !rsp_channel_on && state.level == 4'd0)
   `LNSC_ASSERT_IMP(a_stall_needs_full, clock, reset, req_stall, out_valid_ff && stage_valid_ff)

endmodule

`default_nettype wire

// File: hdl/lnsc_core.sv
`default_nettype none

module lnsc_core
   import lnsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  request_type      req,
   output result_type       result,
   output state_type        state
);

   state_type st_ff;
   state_type st_in;
   logic [7:0] rdata;

   always_comb begin
      logic [31:0] pc_dec;
      logic        fb;
      logic        len_bit;
      st_in  = st_ff;
      rdata  = RDATA_IDLE;
      pc_dec = st_ff.period_count - 32'd1;
      fb      = st_ff.shift_reg[0] ^ st_ff.shift_reg[1];
      len_bit = req.wdata[6];
      unique case (req.func)
         FUNC_TICK: begin
            st_in.period_count = pc_dec;
            if (pc_dec == 32'd0) begin
               st_in.period_count = reload_value(st_ff.divisor_code, st_ff.clock_shift);
               if (st_ff.clock_shift < CLOCK_SHIFT_STOP) begin
                  st_in.shift_reg = {fb, st_ff.shift_reg[14:1]};
                  if (st_ff.narrow_mode) begin
                     st_in.shift_reg[6] = fb;
                  end
               end
            end
            st_in.last_sample = (st_ff.active && !st_in.shift_reg[0]) ? st_ff.level : 4'd0;
         end
         FUNC_LENGTH: begin
            if (st_ff.length_on) begin
               st_in.length_left = st_ff.length_left - 7'd1;
               if (st_in.length_left == 7'd0) begin
                  st_in.active = 1'b0;
               end
            end
         end
         FUNC_ENVELOPE: begin
            if (st_ff.active && st_ff.env_period != 3'd0) begin
               st_in.env_count = st_ff.env_count - 4'd1;
               if (st_in.env_count == 4'd0) begin
                  st_in.env_count = {1'b0, st_ff.env_period};
                  if (!st_ff.env_up && st_ff.level != 4'd0) begin
                     st_in.level = st_ff.level - 4'd1;
                  end
                  if (st_ff.env_up && st_ff.level != 4'd15) begin
                     st_in.level = st_ff.level + 4'd1;
                  end
               end
            end
         end
         FUNC_READ: begin
            unique case (req.addr)
               ADDR_ENVELOPE: rdata = {st_ff.env_start_volume, st_ff.env_up, st_ff.env_period};
               ADDR_POLY:     rdata = {st_ff.clock_shift, st_ff.narrow_mode, st_ff.divisor_code};
               ADDR_CONTROL:  rdata = {1'b1, st_ff.length_on, 6'h3F};
               default:       rdata = RDATA_IDLE;
            endcase
         end
         FUNC_WRITE: begin
            unique case (req.addr)
               ADDR_LENGTH: begin
                  st_in.length_left = LENGTH_FULL - {1'b0, req.wdata[5:0]};
               end
               ADDR_ENVELOPE: begin
                  st_in.env_start_volume = req.wdata[7:4];
                  st_in.env_up           = req.wdata[3];
                  st_in.env_period       = req.wdata[2:0];
                  if (req.wdata[7:3] == 5'd0) begin
                     st_in.active = 1'b0;
                  end
               end
               ADDR_POLY: begin
                  st_in.clock_shift  = req.wdata[7:4];
                  st_in.narrow_mode  = req.wdata[3];
                  st_in.divisor_code = req.wdata[2:0];
                  st_in.period_count = reload_value(req.wdata[2:0], req.wdata[7:4]);
               end
               ADDR_CONTROL: begin
                  if (req.phase_odd && !st_ff.length_on && len_bit) begin
                     st_in.length_left = st_ff.length_left - 7'd1;
                     if (st_in.length_left == 7'd0) begin
                        st_in.active = 1'b0;
                     end
                  end
                  st_in.length_on = len_bit;
                  if (req.wdata[7]) begin
                     st_in.active    = (st_ff.env_start_volume != 4'd0) || st_ff.env_up;
                     st_in.shift_reg = LFSR_SEED;
                     st_in.env_count = (st_ff.env_period != 3'd0) ?
                                       {1'b0, st_ff.env_period} : ENV_COUNT_ZERO_PERIOD;
                     st_in.level     = st_ff.env_start_volume;
                     if (st_in.length_left == 7'd0) begin
                        st_in.length_left = (req.phase_odd && len_bit) ?
                                            (LENGTH_FULL - 7'd1) : LENGTH_FULL;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_POWER: begin
            st_in = '0;
            st_in.length_left = req.init_length ? LENGTH_FULL : st_ff.length_left;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   assign result.rdata      = rdata;
   assign result.sample_out = st_in.last_sample;
   assign result.channel_on = st_in.active;
   assign state             = st_ff;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lnsc_pkg::*;

   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NOISY_ITEMS = 600;
   localparam int TOTAL_ITEMS = 700;

   typedef struct packed {
      logic [14:0] lfsr;
      logic [31:0] period;
      logic [3:0]  shift;
      logic        narrow;
      logic [2:0]  div_code;
      logic [6:0]  len_left;
      logic        len_on;
      logic [3:0]  vol_init;
      logic        vol_up;
      logic [2:0]  env_per;
      logic [3:0]  env_cnt;
      logic [3:0]  volume;
      logic        enabled;
      logic [3:0]  sample;
   } noise_state_type;

   typedef struct {
      request_type req;
      bit          typed;
      result_type  want;
   } probe_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [15:0] req_addr;
   logic [7:0]  req_wdata;
   logic        req_phase_odd;
   logic        req_init_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_rdata;
   logic [3:0]  rsp_sample_out;
   logic        rsp_channel_on;

   noise_state_type chan;
   result_type   pending_results[$];
   int           mismatch_count = 0;
   int           sent_count = 0;
   int           cycle_count = 0;
   bit           idling_on = 1'b0;

   probe_row_type directed_rows [26] = '{
      '{'{FUNC_READ, ADDR_ENVELOPE, 8'h00, 1'b0, 1'b0}, 1'b1, '{8'h00, 4'h0, 1'b0}},
      '{'{FUNC_READ, ADDR_POLY, 8'h00, 1'b0, 1'b0}, 1'b1, '{8'h00, 4'h0, 1'b0}},
      '{'{FUNC_READ, ADDR_CONTROL, 8'h00, 1'b0, 1'b0}, 1'b1, '{8'hBF, 4'h0, 1'b0}},
      '{'{FUNC_READ, ADDR_LENGTH, 8'h00, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_SPARE_LO, 16'h0000, 8'hFF, 1'b1, 1'b1}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_SPARE_HI, 16'hFFFF, 8'h00, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_TICK, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_LENGTH, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_WRITE, ADDR_ENVELOPE, 8'hF8, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_WRITE, ADDR_POLY, 8'h00, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_WRITE, ADDR_LENGTH, 8'h3F, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_WRITE, ADDR_CONTROL, 8'hC0, 1'b1, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b1}},
      '{'{FUNC_WRITE, ADDR_POLY, 8'h08, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_TICK, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_TICK, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_TICK, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_TICK, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_LENGTH, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_WRITE, ADDR_ENVELOPE, 8'h1F, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_ENVELOPE, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_WRITE, ADDR_POLY, 8'hF7, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_WRITE, 16'hFFFF, 8'hFF, 1'b1, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE, ADDR_ENVELOPE, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{FUNC_POWER, 16'h0000, 8'h00, 1'b0, 1'b1}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_POWER, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b1, '{RDATA_IDLE, 4'h0, 1'b0}},
      '{'{FUNC_READ, ADDR_CONTROL, 8'h00, 1'b0, 1'b0}, 1'b1, '{8'hBF, 4'h0, 1'b0}}
   };

   lfsr_noise_sound_channel_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_addr        (req_addr),
      .req_wdata       (req_wdata),
      .req_phase_odd   (req_phase_odd),
      .req_init_length (req_init_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rdata       (rsp_rdata),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_channel_on  (rsp_channel_on)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic result_type predict_channel_event(input request_type req);
      result_type res;
      logic       fb;
      logic       len_bit;
      res = '0;
      res.rdata = RDATA_IDLE;
      case (req.func)
         FUNC_TICK: begin
            chan.period = chan.period - 32'd1;
            if (chan.period == 32'd0) begin
               chan.period = 32'(DIVISOR_TABLE[chan.div_code]) << chan.shift;
               if (chan.shift < CLOCK_SHIFT_STOP) begin
                  fb = chan.lfsr[0] ^ chan.lfsr[1];
                  chan.lfsr = {fb, chan.lfsr[14:1]};
                  if (chan.narrow) begin
                     chan.lfsr[6] = fb;
                  end
               end
            end
            chan.sample = (chan.enabled && !chan.lfsr[0]) ? chan.volume : 4'd0;
         end
         FUNC_LENGTH: begin
            if (chan.len_on) begin
               chan.len_left = chan.len_left - 7'd1;
               if (chan.len_left == 7'd0) begin
                  chan.enabled = 1'b0;
               end
            end
         end
         FUNC_ENVELOPE: begin
            if (chan.enabled && chan.env_per != 3'd0) begin
               chan.env_cnt = chan.env_cnt - 4'd1;
               if (chan.env_cnt == 4'd0) begin
                  chan.env_cnt = {1'b0, chan.env_per};
                  if (!chan.vol_up && chan.volume > 4'd0) begin
                     chan.volume = chan.volume - 4'd1;
                  end
                  if (chan.vol_up && chan.volume < 4'd15) begin
                     chan.volume = chan.volume + 4'd1;
                  end
               end
            end
         end
         FUNC_READ: begin
            case (req.addr)
               ADDR_ENVELOPE: res.rdata = {chan.vol_init, chan.vol_up, chan.env_per};
               ADDR_POLY:     res.rdata = {chan.shift, chan.narrow, chan.div_code};
               ADDR_CONTROL:  res.rdata = {1'b1, chan.len_on, 6'h3F};
               default:       res.rdata = RDATA_IDLE;
            endcase
         end
         FUNC_WRITE: begin
            case (req.addr)
               ADDR_LENGTH: begin
                  chan.len_left = LENGTH_FULL - {1'b0, req.wdata[5:0]};
               end
               ADDR_ENVELOPE: begin
                  chan.vol_init = req.wdata[7:4];
                  chan.vol_up = req.wdata[3];
                  chan.env_per = req.wdata[2:0];
                  if (chan.vol_init == 4'd0 && !chan.vol_up) begin
                     chan.enabled = 1'b0;
                  end
               end
               ADDR_POLY: begin
                  chan.shift = req.wdata[7:4];
                  chan.narrow = req.wdata[3];
                  chan.div_code = req.wdata[2:0];
                  chan.period = 32'(DIVISOR_TABLE[chan.div_code]) << chan.shift;
               end
               ADDR_CONTROL: begin
                  len_bit = req.wdata[6];
                  if (req.phase_odd && !chan.len_on && len_bit) begin
                     chan.len_left = chan.len_left - 7'd1;
                     if (chan.len_left == 7'd0) begin
                        chan.enabled = 1'b0;
                     end
                  end
                  chan.len_on = len_bit;
                  if (req.wdata[7]) begin
                     chan.enabled = (chan.vol_init != 4'd0) || chan.vol_up;
                     chan.lfsr = LFSR_SEED;
                     chan.env_cnt = (chan.env_per != 3'd0) ? {1'b0, chan.env_per}
                                                           : ENV_COUNT_ZERO_PERIOD;
                     chan.volume = chan.vol_init;
                     if (chan.len_left == 7'd0) begin
                        chan.len_left = (req.phase_odd && chan.len_on) ? LENGTH_FULL - 7'd1
                                                                       : LENGTH_FULL;
                     end
                  end
               end
               default: ;
            endcase
         end
         FUNC_POWER: begin
            if (req.init_length) begin
               chan.len_left = LENGTH_FULL;
            end
            chan.lfsr = '0;
            chan.period = '0;
            chan.shift = '0;
            chan.narrow = 1'b0;
            chan.div_code = '0;
            chan.len_on = 1'b0;
            chan.vol_init = '0;
            chan.vol_up = 1'b0;
            chan.env_per = '0;
            chan.env_cnt = '0;
            chan.volume = '0;
            chan.enabled = 1'b0;
            chan.sample = '0;
         end
         default: ;
      endcase
      res.sample_out = chan.sample;
      res.channel_on = chan.enabled;
      return res;
   endfunction

   task automatic send_request(input request_type req, input bit typed,
                               input result_type want);
      result_type predicted;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= req.func;
      req_addr <= req.addr;
      req_wdata <= req.wdata;
      req_phase_odd <= req.phase_odd;
      req_init_length <= req.init_length;
      do @(posedge clock); while (req_stall);
      predicted = predict_channel_event(req);
      pending_results.push_back(typed ? want : predicted);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic issue(input logic [2:0] func, input logic [15:0] addr,
                        input logic [7:0] wdata, input logic odd, input logic init_len);
      request_type req;
      req = '{func, addr, wdata, odd, init_len};
      send_request(req, 1'b0, '0);
   endtask

   task automatic play_phrase();
      int          pick;
      logic [15:0] addr;
      logic [3:0]  shift;
      logic [2:0]  div;
      logic [5:0]  len_code;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            addr = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 16'hFFFF))
                                               : ADDR_LENGTH + 16'($urandom_range(0, 3));
            issue(3'($urandom_range(FUNC_TICK, FUNC_SPARE_HI)), addr,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
         end
      end else begin
         if ($urandom_range(0, 9) == 0) begin
            issue(FUNC_POWER, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 1) != 0) begin
            issue(FUNC_WRITE, ADDR_ENVELOPE, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0);
         end
         if ($urandom_range(0, 1) != 0) begin
            shift = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, 1));
            div = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(0, 1));
            issue(FUNC_WRITE, ADDR_POLY, {shift, 1'($urandom_range(0, 1)), div},
                  1'($urandom_range(0, 1)), 1'b0);
         end
         if ($urandom_range(0, 3) == 0) begin
            len_code = ($urandom_range(0, 1) != 0) ? 6'h3F - 6'($urandom_range(0, 3))
                                                   : 6'($urandom_range(0, 63));
            issue(FUNC_WRITE, ADDR_LENGTH, {2'($urandom_range(0, 3)), len_code},
                  1'($urandom_range(0, 1)), 1'b0);
         end
         if ($urandom_range(0, 1) != 0) begin
            issue(FUNC_WRITE, ADDR_CONTROL,
                  {1'($urandom_range(0, 7) != 0), 7'($urandom_range(0, 127))},
                  1'($urandom_range(0, 1)), 1'b0);
         end
         repeat ($urandom_range(10, 60)) begin
            pick = $urandom_range(0, 99);
            addr = ADDR_LENGTH + 16'($urandom_range(0, 3));
            if (pick < 70) begin
               issue(FUNC_TICK, addr, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else if (pick < 80) begin
               issue(FUNC_LENGTH, addr, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else if (pick < 90) begin
               issue(FUNC_ENVELOPE, addr, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else if (pick < 95) begin
               issue(FUNC_READ, addr, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else begin
               issue(FUNC_WRITE, addr, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'b0);
            end
         end
      end
   endtask

   initial begin
      int hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_rdata !== want.rdata) begin
               $error("rdata: expected %02h, got %02h", want.rdata, rsp_rdata);
               mismatch_count++;
            end
            if (rsp_sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, got %0d", want.sample_out, rsp_sample_out);
               mismatch_count++;
            end
            if (rsp_channel_on !== want.channel_on) begin
               $error("channel_on: expected %0b, got %0b", want.channel_on, rsp_channel_on);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_TICK;
      req_addr <= '0;
      req_wdata <= '0;
      req_phase_odd <= 1'b0;
      req_init_length <= 1'b0;
      chan = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      idling_on = 1'b1;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      while (sent_count < NOISY_ITEMS) begin
         idling_on = ($urandom_range(0, 3) != 0);
         play_phrase();
      end
      idling_on = 1'b0;
      while (sent_count < TOTAL_ITEMS) begin
         play_phrase();
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lnsc_pkg.sv
hdl/lnsc_core.sv
hdl/lfsr_noise_sound_channel_top.sv
bench/tb_top.sv
